### rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is held
`define BM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define BM_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/bmorph_pkg.sv
package bmorph_pkg;

  localparam int MAX_ELEM = 5;
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  // window spans two element sizes minus the current line / column
  localparam int WIN    = 2 * MAX_ELEM - 1;
  localparam int WIN_IW = (WIN > 1) ? $clog2(WIN) : 1;

  localparam int LS_COLS = MAX_COLS + 2 * MAX_ELEM;
  localparam int COL_W   = $clog2(LS_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS + 2 * MAX_ELEM);

  localparam int DIM_W  = 11;
  localparam int ELEM_W = 3;
  localparam int MASK_W = 25;
  localparam int PIX_W  = 8;
  localparam int POS_W  = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 24;
  localparam int OUT_PAD_W   = TDATA_OUT_W - 2 * POS_W - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OP_MODE,
    REG_IMAGE_ROWS,
    REG_IMAGE_COLS,
    REG_ELEM_ROWS,
    REG_ELEM_COLS,
    REG_ANCHOR_ROW,
    REG_ANCHOR_COL,
    REG_ELEM_MASK
  } cfg_reg_e;

  typedef enum logic {
    MODE_DILATE,
    MODE_ERODE
  } op_mode_e;

  // one column of foreground bits, bit k is k+1 lines above the current one
  typedef logic [WIN-1:0] lb_word_t;
  // window indexed [column back][line back]
  typedef logic [WIN-1:0][WIN-1:0] win_t;

endpackage

### rtl/core/binary_morphology_dilate_erode.sv
// Binary dilation / erosion of a zero-framed image stream.
// Config channel: cfg_index_i selects a register (op mode, image rows and
// columns, element rows and columns, anchor row and column, element mask),
// cfg_data_i carries the value. Any write restarts the frame. While a write
// is offered the pixel input is held off.
// Pixel input: one framed pixel per item in raster order, nonzero is
// foreground; the frame is element-sized on every side.
// Result output: one item per image position, sent with the pixel that
// completes its window; tlast marks the last result of the image.
// Throughput is one pixel per clock while no write is offered and the
// receiver takes results; a result passes the input stage and then the
// output register. The line store is one memory read when a pixel is
// accepted and written when it leaves the input stage, so it sustains
// one pixel per clock. When the receiver stalls, the output register
// holds its item and tready drops once the input stage holds a pixel.
// Reset clears the counters, the pipeline valids and the registers to their
// defaults (dilation, 1x1 image, 3x3 element, anchor 1,1, empty mask); the
// line store is not cleared and needs no clearing pass.
module binary_morphology_dilate_erode
  import bmorph_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] pixel_value

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [0] result_bit, [10:1] out_row,
                                                 // [20:11] out_col, [23:21] zero
  output logic                   m_axis_tlast    // frame_end
);

  // configuration registers
  op_mode_e          op_mode_q;
  logic [DIM_W-1:0]  image_rows_q, image_cols_q;
  logic [ELEM_W-1:0] elem_rows_q, elem_cols_q, anchor_row_q, anchor_col_q;
  logic [MASK_W-1:0] elem_mask_q;

  // saturated geometry
  logic [ELEM_W-1:0] er, ec, ar, ac;
  logic [DIM_W-1:0]  ir, ic;
  logic [ROW_W-1:0]  frame_rows_m1, edge_rows;
  logic [COL_W-1:0]  frame_cols_m1, edge_cols;

  logic [ROW_W-1:0]  row_cnt_q, row_cnt_d;
  logic [COL_W-1:0]  col_cnt_q, col_cnt_d;
  logic              in_acc, cfg_wr, row_last, col_last, pix_inside;

  // input stage
  logic              a_vld_q, a_adv;
  logic              a_emit_q, a_fg_q, a_last_q;
  logic [POS_W-1:0]  a_row_q, a_col_q;
  logic [COL_W-1:0]  a_addr_q;
  lb_word_t          rd_q;
  lb_word_t          line_mem [LS_COLS];

  win_t              win_q, win_d, wm_q, wm_d;
  logic              res_bit;

  // output register
  logic              out_vld_q, out_bit_q, out_last_q;
  logic [POS_W-1:0]  out_row_q, out_col_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_comb begin
    if (elem_rows_q == '0) begin
      er = ELEM_W'(1);
    end else if ({1'b0, elem_rows_q} > (ELEM_W+1)'(MAX_ELEM)) begin
      er = ELEM_W'(MAX_ELEM);
    end else begin
      er = elem_rows_q;
    end
    if (elem_cols_q == '0) begin
      ec = ELEM_W'(1);
    end else if ({1'b0, elem_cols_q} > (ELEM_W+1)'(MAX_ELEM)) begin
      ec = ELEM_W'(MAX_ELEM);
    end else begin
      ec = elem_cols_q;
    end
    ar = (anchor_row_q > er - 1'b1) ? er - 1'b1 : anchor_row_q;
    ac = (anchor_col_q > ec - 1'b1) ? ec - 1'b1 : anchor_col_q;
    if (image_rows_q == '0) begin
      ir = DIM_W'(1);
    end else if ({1'b0, image_rows_q} > (DIM_W+1)'(MAX_ROWS)) begin
      ir = DIM_W'(MAX_ROWS);
    end else begin
      ir = image_rows_q;
    end
    if (image_cols_q == '0) begin
      ic = DIM_W'(1);
    end else if ({1'b0, image_cols_q} > (DIM_W+1)'(MAX_COLS)) begin
      ic = DIM_W'(MAX_COLS);
    end else begin
      ic = image_cols_q;
    end
    edge_rows     = ROW_W'({er, 1'b0});
    edge_cols     = COL_W'({ec, 1'b0});
    frame_rows_m1 = ROW_W'(ir) + edge_rows - 1'b1;
    frame_cols_m1 = COL_W'(ic) + edge_cols - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q    <= MODE_DILATE;
      image_rows_q <= DIM_W'(1);
      image_cols_q <= DIM_W'(1);
      elem_rows_q  <= ELEM_W'(3);
      elem_cols_q  <= ELEM_W'(3);
      anchor_row_q <= ELEM_W'(1);
      anchor_col_q <= ELEM_W'(1);
      elem_mask_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_OP_MODE:    op_mode_q    <= op_mode_e'(cfg_data_i[0]);
        REG_IMAGE_ROWS: image_rows_q <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_COLS: image_cols_q <= cfg_data_i[DIM_W-1:0];
        REG_ELEM_ROWS:  elem_rows_q  <= cfg_data_i[ELEM_W-1:0];
        REG_ELEM_COLS:  elem_cols_q  <= cfg_data_i[ELEM_W-1:0];
        REG_ANCHOR_ROW: anchor_row_q <= cfg_data_i[ELEM_W-1:0];
        REG_ANCHOR_COL: anchor_col_q <= cfg_data_i[ELEM_W-1:0];
        REG_ELEM_MASK:  elem_mask_q  <= cfg_data_i[MASK_W-1:0];
      endcase
    end
  end

  // raster counters
  assign a_adv         = a_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = (!a_vld_q || a_adv) && !cfg_valid_i;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign row_last      = (row_cnt_q == frame_rows_m1);
  assign col_last      = (col_cnt_q == frame_cols_m1);
  assign pix_inside    = (row_cnt_q >= ROW_W'(er)) && (row_cnt_q < ROW_W'(er) + ROW_W'(ir))
                      && (col_cnt_q >= COL_W'(ec)) && (col_cnt_q < COL_W'(ec) + COL_W'(ic));

  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (cfg_wr) begin
      row_cnt_d = '0;
      col_cnt_d = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_cnt_d = '0;
        row_cnt_d = row_last ? '0 : row_cnt_q + 1'b1;
      end else begin
        col_cnt_d = col_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      if (in_acc) begin
        a_vld_q <= 1'b1;
      end else if (a_adv) begin
        a_vld_q <= 1'b0;
      end
      if (a_adv) begin
        out_vld_q <= a_emit_q;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_fg_q   <= (|s_axis_tdata[PIX_W-1:0]) && pix_inside;
      a_emit_q <= (row_cnt_q >= edge_rows) && (col_cnt_q >= edge_cols);
      a_last_q <= row_last && col_last;
      a_row_q  <= POS_W'(row_cnt_q - edge_rows);
      a_col_q  <= POS_W'(col_cnt_q - edge_cols);
      a_addr_q <= col_cnt_q;
    end
  end

  // line store: read the column when a pixel arrives, write it back shifted
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[col_cnt_q];
    end
    if (a_adv) begin
      line_mem[a_addr_q] <= lb_word_t'({rd_q, a_fg_q});
    end
  end

  // win_q[k] holds the column k+1 to the left of the pixel in the input stage
  always_comb begin
    win_d[0] = rd_q;
    for (int k = 1; k < WIN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      win_q <= win_d;
    end
  end

  // element mask mapped onto window offsets, mirrored for dilation
  always_comb begin
    int  dr;
    int  dc;
    logic en;
    wm_d = '0;
    for (int r = 0; r < MAX_ELEM; r++) begin
      for (int c = 0; c < MAX_ELEM; c++) begin
        en = elem_mask_q[r*MAX_ELEM+c] && (r < int'(er)) && (c < int'(ec));
        if (op_mode_q == MODE_DILATE) begin
          dr = int'(er) - 1 - int'(ar) + r;
          dc = int'(ec) - 1 - int'(ac) + c;
        end else begin
          dr = int'(er) - 1 + int'(ar) - r;
          dc = int'(ec) - 1 + int'(ac) - c;
        end
        if (en) begin
          wm_d[WIN_IW'(dc)][WIN_IW'(dr)] = 1'b1;
        end
      end
    end
    // erosion also needs the centre itself
    if (op_mode_q == MODE_ERODE) begin
      wm_d[WIN_IW'(int'(ec) - 1)][WIN_IW'(int'(er) - 1)] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    wm_q <= wm_d;
  end

  assign res_bit = (op_mode_q == MODE_ERODE) ? &(win_q | ~wm_q) : |(win_q & wm_q);

  always_ff @(posedge clk_i) begin
    if (a_adv && a_emit_q) begin
      out_bit_q  <= res_bit;
      out_row_q  <= a_row_q;
      out_col_q  <= a_col_q;
      out_last_q <= a_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_q, out_row_q, out_bit_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### rtl/core/bmorph_checker.sv
`include "assert_macros.svh"

module bmorph_checker
  import bmorph_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_valid_i,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // stalled result item holds
  `BM_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result item changed while stalled")

  // a register write never meets a pixel accept
  `BM_ASSERT(a_cfg_holds_input, clk_i, rst_ni, cfg_valid_i |-> !s_axis_tready, "pixel input open during a register write")

  // an empty output only fills from an accepted pixel that passed the input stage
  `BM_ASSERT(a_out_from_input, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without a matching pixel")

  `BM_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid, "result offered during reset")

endmodule

bind binary_morphology_dilate_erode bmorph_checker u_bmorph_checker (.*);

### bench/binary_morphology_dilate_erode_tb.sv
module binary_morphology_dilate_erode_tb;
  import bmorph_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS = 1000;
  localparam int WD_LIMIT   = 2000;
  localparam int SETTLE_CYC = 8;
  localparam int LS_ROWS    = 2 * MAX_ELEM;

  typedef struct {
    logic       value;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } morph_res_t;

  typedef enum logic {
    STEP_REG,
    STEP_FRAME
  } step_kind_e;

  typedef struct {
    step_kind_e             kind;
    cfg_reg_e               idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [PIX_W-1:0]       centre;
    logic [PIX_W-1:0]       border;
    logic                   exp_value;
  } dir_step_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // typed expectation travelling alongside the pixel, sampled on acceptance
  logic                   s_tag_on = 1'b0;
  morph_res_t             s_tag_res;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int err_cnt = 0;
  int idle_cnt = 0;
  int n_pix = 0;
  int n_res = 0;
  int n_writes = 0;
  int n_frames = 0;
  int n_partial = 0;

  morph_res_t morph_expect_q[$];

  // predictor state
  op_mode_e          reg_op = MODE_DILATE;
  logic [DIM_W-1:0]  reg_irows = 11'd1;
  logic [DIM_W-1:0]  reg_icols = 11'd1;
  logic [ELEM_W-1:0] reg_erows = 3'd3;
  logic [ELEM_W-1:0] reg_ecols = 3'd3;
  logic [ELEM_W-1:0] reg_arow = 3'd1;
  logic [ELEM_W-1:0] reg_acol = 3'd1;
  logic [MASK_W-1:0] reg_mask = '0;
  int g_er = 3, g_ec = 3, g_ir = 1, g_ic = 1, g_ar = 1, g_ac = 1;
  int pix_row = 0, pix_col = 0;
  bit fg_lines [LS_ROWS][LS_COLS];

  dir_step_t dir_steps [9] = '{
    '{STEP_REG,   REG_ELEM_ROWS, 25'd1,        8'h00, 8'h00, 1'b0},
    '{STEP_REG,   REG_ELEM_COLS, 25'd1,        8'h00, 8'h00, 1'b0},
    // empty mask, nothing dilates
    '{STEP_FRAME, REG_OP_MODE,   25'd0,        8'hFF, 8'hFF, 1'b0},
    '{STEP_REG,   REG_ELEM_MASK, 25'd1,        8'h00, 8'h00, 1'b0},
    '{STEP_FRAME, REG_OP_MODE,   25'd0,        8'h01, 8'h00, 1'b1},
    // border pixels read as background whatever their value
    '{STEP_FRAME, REG_OP_MODE,   25'd0,        8'h00, 8'hFF, 1'b0},
    '{STEP_REG,   REG_OP_MODE,   25'd1,        8'h00, 8'h00, 1'b0},
    '{STEP_REG,   REG_ELEM_MASK, 25'h1FFFFFF,  8'h00, 8'h00, 1'b0},
    // mask bits outside a 1x1 element must not see the border
    '{STEP_FRAME, REG_OP_MODE,   25'd0,        8'h80, 8'h00, 1'b1}
  };

  binary_morphology_dilate_erode u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (cfg_reg_e'(idx))
      REG_OP_MODE:    reg_op = op_mode_e'(val[0]);
      REG_IMAGE_ROWS: reg_irows = val[DIM_W-1:0];
      REG_IMAGE_COLS: reg_icols = val[DIM_W-1:0];
      REG_ELEM_ROWS:  reg_erows = val[ELEM_W-1:0];
      REG_ELEM_COLS:  reg_ecols = val[ELEM_W-1:0];
      REG_ANCHOR_ROW: reg_arow = val[ELEM_W-1:0];
      REG_ANCHOR_COL: reg_acol = val[ELEM_W-1:0];
      REG_ELEM_MASK:  reg_mask = val[MASK_W-1:0];
      default: ;
    endcase
    g_er = clip(int'(reg_erows), 1, MAX_ELEM);
    g_ec = clip(int'(reg_ecols), 1, MAX_ELEM);
    g_ir = clip(int'(reg_irows), 1, MAX_ROWS);
    g_ic = clip(int'(reg_icols), 1, MAX_COLS);
    g_ar = clip(int'(reg_arow), 0, g_er - 1);
    g_ac = clip(int'(reg_acol), 0, g_ec - 1);
    pix_row = 0;
    pix_col = 0;
  endfunction

  function automatic bit in_image(int r, int c);
    return r >= g_er && r < g_er + g_ir && c >= g_ec && c < g_ec + g_ic;
  endfunction

  function automatic bit fg_at(int r, int c);
    if (!in_image(r, c)) return 1'b0;
    return fg_lines[r % LS_ROWS][c];
  endfunction

  // stores the pixel and returns 1 when it completes a window
  function automatic bit morph_predict(input logic [PIX_W-1:0] pix, output morph_res_t res);
    int fr, fc, p, q, i, j;
    bit hit;
    res = '{value: 1'b0, row: '0, col: '0, last: 1'b0};
    fr = g_ir + 2 * g_er;
    fc = g_ic + 2 * g_ec;
    p = (pix_row >= fr) ? 0 : pix_row;
    q = (pix_col >= fc) ? 0 : pix_col;
    fg_lines[p % LS_ROWS][q] = (pix != '0) && in_image(p, q);
    if (q + 1 >= fc) begin
      pix_col = 0;
      pix_row = (p + 1 >= fr) ? 0 : p + 1;
    end else begin
      pix_col = q + 1;
      pix_row = p;
    end
    if (p < 2 * g_er || q < 2 * g_ec) return 1'b0;
    i = p - g_er;
    j = q - g_ec;
    if (reg_op == MODE_DILATE) begin
      hit = 1'b0;
      for (int r = 0; r < g_er; r++)
        for (int c = 0; c < g_ec; c++)
          if (reg_mask[r * MAX_ELEM + c] && fg_at(i + g_ar - r, j + g_ac - c)) hit = 1'b1;
    end else begin
      hit = fg_at(i, j);
      for (int r = 0; r < g_er; r++)
        for (int c = 0; c < g_ec; c++)
          if (reg_mask[r * MAX_ELEM + c] && !fg_at(i - g_ar + r, j - g_ac + c)) hit = 1'b0;
    end
    res.value = hit;
    res.row = 10'(i - g_er);
    res.col = 10'(j - g_ec);
    res.last = (p == fr - 1) && (q == fc - 1);
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : mon
    morph_res_t want;
    morph_res_t got;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready_o) begin
        load_reg(cfg_index, cfg_data);
        n_writes++;
        moved = 1'b1;
      end
      if (s_tvalid && s_axis_tready) begin
        n_pix++;
        moved = 1'b1;
        if (morph_predict(s_tdata, want)) begin
          if (s_tag_on) want = s_tag_res;
          morph_expect_q.push_back(want);
        end
      end
      if (m_axis_tvalid && m_tready) begin
        moved = 1'b1;
        n_res++;
        got.value = m_axis_tdata[0];
        got.row = m_axis_tdata[10:1];
        got.col = m_axis_tdata[20:11];
        got.last = m_axis_tlast;
        if (morph_expect_q.size() == 0) begin
          $error("result with nothing pending: row %0d col %0d", got.row, got.col);
          err_cnt++;
        end else begin
          want = morph_expect_q.pop_front();
          if (got.value !== want.value) begin
            $error("result_bit mismatch: expected %0d, got %0d", want.value, got.value);
            err_cnt++;
          end
          if (got.row !== want.row) begin
            $error("out_row mismatch: expected %0d, got %0d", want.row, got.row);
            err_cnt++;
          end
          if (got.col !== want.col) begin
            $error("out_col mismatch: expected %0d, got %0d", want.col, got.col);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $error("frame_end mismatch: expected %0d, got %0d", want.last, got.last);
            err_cnt++;
          end
          if (m_axis_tdata[TDATA_OUT_W-1:2*POS_W+1] !== '0) begin
            $error("pad mismatch: expected 0, got %0d", m_axis_tdata[TDATA_OUT_W-1:2*POS_W+1]);
            err_cnt++;
          end
        end
      end
      idle_cnt = moved ? 0 : idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results pending",
                 WD_LIMIT, morph_expect_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic tag_on,
                            input morph_res_t tag_res);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tag_on <= tag_on;
    s_tag_res <= tag_res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop the pixel stream, let every pending result out and the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (morph_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idle(input int mode);
    case (mode % 4)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 63; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 63; end
      default: begin snd_idle_pct = 36; rcv_stall_pct = 36; end
    endcase
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel(input int density);
    if ($urandom_range(99) >= density) return '0;
    case ($urandom_range(7))
      0: return 8'hFF;
      1: return 8'h01;
      default: return PIX_W'($urandom_range(1, 255));
    endcase
  endfunction

  initial begin : stim
    morph_res_t typed;
    morph_res_t none;
    logic [CFG_DATA_W-1:0] mask_v;
    int phase, rand_pix, density, nfr, fsize, cut;
    bit wide, tall;

    // falling edge at time zero so the asynchronous reset takes effect at once
    rst_ni <= 1'b0;
    none = '{value: 1'b0, row: '0, col: '0, last: 1'b0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: 1x1 image with a 1x1 element, so every frame is 3x3
    set_idle(0);
    foreach (dir_steps[k]) begin
      if (dir_steps[k].kind == STEP_REG) begin
        if (k == 0 || dir_steps[k-1].kind != STEP_REG) settle();
        write_reg(dir_steps[k].idx, dir_steps[k].val);
        if (k == $size(dir_steps) - 1 || dir_steps[k+1].kind != STEP_REG) close_cfg();
      end else begin
        typed = '{value: dir_steps[k].exp_value, row: '0, col: '0, last: 1'b1};
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            push_pixel((r == 1 && c == 1) ? dir_steps[k].centre : dir_steps[k].border,
                       1'b1, typed);
        n_frames++;
      end
    end

    // random part: one register setting per phase, idling rotates per phase
    phase = 0;
    rand_pix = 0;
    while (phase < 4 || rand_pix < RAND_ITEMS) begin
      tall = (phase == 1);
      wide = (phase == 3);
      set_idle(phase);
      settle();
      case ($urandom_range(3))
        0: mask_v = '0;
        1: mask_v = '1;
        default: mask_v = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_OP_MODE, CFG_DATA_W'($urandom_range(1)));
      if (tall) begin
        write_reg(REG_IMAGE_ROWS, 25'd2047);
        write_reg(REG_IMAGE_COLS, 25'd1);
        write_reg(REG_ELEM_ROWS, 25'd5);
        write_reg(REG_ELEM_COLS, 25'd0);
        write_reg(REG_ANCHOR_ROW, 25'd7);
        write_reg(REG_ANCHOR_COL, 25'd0);
      end else if (wide) begin
        write_reg(REG_IMAGE_ROWS, 25'd0);
        write_reg(REG_IMAGE_COLS, 25'd1024);
        write_reg(REG_ELEM_ROWS, 25'd1);
        write_reg(REG_ELEM_COLS, 25'd5);
        write_reg(REG_ANCHOR_ROW, 25'd0);
        write_reg(REG_ANCHOR_COL, 25'd4);
      end else begin
        write_reg(REG_IMAGE_ROWS, CFG_DATA_W'($urandom_range(0, 6)));
        write_reg(REG_IMAGE_COLS, CFG_DATA_W'($urandom_range(0, 8)));
        write_reg(REG_ELEM_ROWS, CFG_DATA_W'($urandom_range(0, 7)));
        write_reg(REG_ELEM_COLS, CFG_DATA_W'($urandom_range(0, 7)));
        write_reg(REG_ANCHOR_ROW, CFG_DATA_W'($urandom_range(0, 7)));
        write_reg(REG_ANCHOR_COL, CFG_DATA_W'($urandom_range(0, 7)));
      end
      write_reg(REG_ELEM_MASK, mask_v);
      close_cfg();

      // erosion needs dense foreground to produce ones, dilation sparse
      density = (reg_op == MODE_ERODE) ? $urandom_range(70, 95) : $urandom_range(10, 40);
      fsize = (g_ir + 2 * g_er) * (g_ic + 2 * g_ec);
      nfr = (tall || wide) ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) begin
        cut = fsize;
        // a cut-short last frame checks the restart on the next write
        if (!tall && !wide && f == nfr - 1 && $urandom_range(99) < 30)
          cut = $urandom_range(1, fsize - 1);
        for (int n = 0; n < cut; n++) push_pixel(rand_pixel(density), 1'b0, none);
        if (!tall && !wide) rand_pix += cut;
        if (cut == fsize) n_frames++;
        else n_partial++;
      end
      phase++;
    end

    settle();
    $display("covered %0d pixels in %0d full and %0d cut frames over %0d register writes",
             n_pix, n_frames, n_partial, n_writes);
    $display("checked %0d results, including 1024-row and 1024-column images", n_res);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/bmorph_pkg.sv
rtl/core/binary_morphology_dilate_erode.sv
rtl/core/bmorph_checker.sv
bench/binary_morphology_dilate_erode_tb.sv
